// File: rtl/core/hvc_pkg.sv
package hvc_pkg;

   // Field widths fixed by the transaction format.
   localparam int CHAN_W   = 3;
   localparam int MODE_W   = 2;
   localparam int SAMPLE_W = 16;

   // Control mode codes carried in each request transaction.
   typedef enum logic [MODE_W-1:0] {
      MODE_OFF   = 2'd0,
      MODE_HYST  = 2'd1,
      MODE_FORCE = 2'd2,
      MODE_DERIV = 2'd3
   } mode_type;

   // One request transaction as held in the input register.
   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [MODE_W-1:0]   mode;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] low_threshold;
      logic [SAMPLE_W-1:0] high_threshold;
   } req_item_type;

   // One response transaction.
   typedef struct packed {
      logic [CHAN_W-1:0] out_channel;
      logic              valve_on;
      logic              any_valve_on;
   } rsp_item_type;

endpackage

// File: rtl/core/hvc_req_stage.sv
module hvc_req_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hvc_pkg::req_item_type req_item,
   input  logic                advance,
   output logic                item_valid,
   output hvc_pkg::req_item_type item
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   hvc_pkg::req_item_type item_ff;

   // The held transaction blocks new ones until the core takes it.
   assign req_stall = in_valid_ff & ~advance;

   always_comb begin
      if (req_stall) begin
         in_valid_in = 1'b1;
      end else begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = in_valid_ff;
   assign item       = item_ff;

   // An accepted transaction always lands in the input register.
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> in_valid_ff)
      else $error("accepted request did not load the input register");

endmodule

// File: rtl/core/hvc_core.sv
module hvc_core #(
   parameter int CHANNELS    = 6,
   parameter int HISTORY_LEN = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  hvc_pkg::req_item_type          item,
   input  logic [hvc_pkg::SAMPLE_W-1:0]   deriv_thr,
   output hvc_pkg::rsp_item_type          result
);

   localparam int PW = $clog2(HISTORY_LEN);
   localparam int SW = hvc_pkg::SAMPLE_W;

   logic [CHANNELS-1:0] valve_ff;
   logic [CHANNELS-1:0] valve_in;
   logic [PW-1:0]       pos_ff  [CHANNELS];
   logic [PW-1:0]       pos_in  [CHANNELS];
   logic [SW-1:0]       hist_ff [CHANNELS][HISTORY_LEN];
   logic [SW-1:0]       hist_in [CHANNELS][HISTORY_LEN];

   logic          in_range;
   logic          cur_on;
   logic [PW-1:0] cur_pos;
   logic [PW-1:0] push_pos;
   logic [PW-1:0] old_pos;
   logic [SW-1:0] oldest;
   logic [SW-1:0] diff;
   logic [SW:0]   mag;
   logic          flat;
   logic          above_high;
   logic          kept_on;
   logic          is_force;
   logic          do_push;
   logic          do_fill;
   logic          on_next;

   // Look up the addressed channel's valve bit and ring position.
   always_comb begin
      in_range = 32'(item.channel) < CHANNELS;
      cur_on   = 1'b0;
      cur_pos  = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (32'(item.channel) == c) begin
            cur_on  = valve_ff[c];
            cur_pos = pos_ff[c];
         end
      end
   end

   // Slot that receives the new sample, and the oldest slot after the push.
   always_comb begin
      if (cur_pos == PW'(HISTORY_LEN - 1)) begin
         push_pos = '0;
      end else begin
         push_pos = cur_pos + 1'b1;
      end
      if (push_pos == PW'(HISTORY_LEN - 1)) begin
         old_pos = '0;
      end else begin
         old_pos = push_pos + 1'b1;
      end
   end

   always_comb begin
      oldest = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         for (int p = 0; p < HISTORY_LEN; p++) begin
            if (32'(item.channel) == c && 32'(old_pos) == p) begin
               oldest = hist_ff[c][p];
            end
         end
      end
   end

   // Magnitude of the wrapped signed change over the window.
   always_comb begin
      diff = item.sample - oldest;
      if (diff[SW-1]) begin
         mag = {1'b1, {SW{1'b0}}} - {1'b0, diff};
      end else begin
         mag = {1'b0, diff};
      end
      flat       = mag <= {1'b0, deriv_thr};
      above_high = item.sample > item.high_threshold;
   end

   // Valve decision for the addressed channel.
   always_comb begin
      is_force = 1'b0;
      kept_on  = 1'b0;
      do_push  = 1'b0;
      do_fill  = 1'b0;
      on_next  = 1'b0;
      case (hvc_pkg::mode_type'(item.mode))
         hvc_pkg::MODE_FORCE: begin
            is_force = 1'b1;
            on_next  = 1'b1;
         end
         hvc_pkg::MODE_HYST, hvc_pkg::MODE_DERIV: begin
            do_push = cur_on && (item.mode == hvc_pkg::MODE_DERIV);
            kept_on = cur_on && !(above_high || (do_push && flat));
            do_fill = !kept_on && (item.sample < item.low_threshold);
            on_next = kept_on || do_fill;
         end
         default: begin
            on_next = 1'b0;
         end
      endcase
   end

   // Next state: only the addressed channel changes, and only on a step.
   always_comb begin
      valve_in = valve_ff;
      pos_in   = pos_ff;
      hist_in  = hist_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         if (step && in_range && 32'(item.channel) == c) begin
            valve_in[c] = on_next;
            if (do_fill) begin
               for (int p = 0; p < HISTORY_LEN; p++) begin
                  hist_in[c][p] = item.high_threshold;
               end
               pos_in[c] = '0;
            end else if (do_push) begin
               hist_in[c][push_pos] = item.sample;
               pos_in[c]            = push_pos;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valve_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c] <= '0;
            for (int p = 0; p < HISTORY_LEN; p++) begin
               hist_ff[c][p] <= '0;
            end
         end
      end else begin
         valve_ff <= valve_in;
         pos_ff   <= pos_in;
         hist_ff  <= hist_in;
      end
   end

   // The response reflects the state as it stands after this step.
   always_comb begin
      result.out_channel  = item.channel;
      result.valve_on     = in_range & on_next;
      result.any_valve_on = |valve_in;
   end

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(valve_ff))
      else $error("valve state changed without a step");

   a_range_holds: assert property (@(posedge clock) disable iff (reset)
      (step && !in_range) |=> valve_ff == $past(valve_ff))
      else $error("out-of-range channel changed valve state");

   a_force_opens: assert property (@(posedge clock) disable iff (reset)
      (step && in_range && is_force) |=> |valve_ff)
      else $error("forced-on step left all valves closed");

endmodule

// File: rtl/core/hysteresis_valve_controller_unit.sv
// A request transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while rsp_stall does not hold the result register.
// The per-channel state is read combinationally and written on the step, so back-to-back
// transactions on the same channel see each other's updates.
// Reset (synchronous, active high) closes all valves, zeroes history and ring
// positions, and clears the derivative threshold.
module hysteresis_valve_controller_unit #(
   parameter int CHANNELS    = 6,
   parameter int HISTORY_LEN = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hvc_pkg::CHAN_W-1:0]        req_channel,
   input  logic [hvc_pkg::MODE_W-1:0]        req_mode,
   input  logic [hvc_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic [hvc_pkg::SAMPLE_W-1:0]      req_low_threshold,
   input  logic [hvc_pkg::SAMPLE_W-1:0]      req_high_threshold,
   // Response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hvc_pkg::CHAN_W-1:0]        rsp_out_channel,
   output logic                              rsp_valve_on,
   output logic                              rsp_any_valve_on,
   // Derivative threshold register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hvc_pkg::SAMPLE_W-1:0]      csr_wdata
);

   hvc_pkg::req_item_type req_item;
   hvc_pkg::req_item_type item;
   hvc_pkg::rsp_item_type result;
   hvc_pkg::rsp_item_type rsp_item_ff;
   logic                  item_valid;
   logic                  advance;
   logic                  step;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [hvc_pkg::SAMPLE_W-1:0] thr_ff;

   assign req_item.channel        = req_channel;
   assign req_item.mode           = req_mode;
   assign req_item.sample         = req_sample;
   assign req_item.low_threshold  = req_low_threshold;
   assign req_item.high_threshold = req_high_threshold;

   // The result register moves whenever it is empty or being drained.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign step    = item_valid && advance;

   hvc_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   hvc_core #(
      .CHANNELS    (CHANNELS),
      .HISTORY_LEN (HISTORY_LEN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .deriv_thr (thr_ff),
      .result    (result)
   );

   // Configuration register; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_wdata;
      end
   end

   // Result register.
   always_comb begin
      if (advance) begin
         rsp_valid_in = item_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_item_ff.out_channel;
   assign rsp_valve_on     = rsp_item_ff.valve_on;
   assign rsp_any_valve_on = rsp_item_ff.any_valve_on;

   a_on_implies_any: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.valve_on) |-> rsp_item_ff.any_valve_on)
      else $error("channel valve open but summary shows all closed");

   a_step_fills_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed transaction did not reach the result register");

endmodule
